/* hdl/kr_pkg.sv */
// Shared types and constants of the keyed record table.
// No dependencies; the cell and the top level take their names from here.
package kr_pkg;

    localparam int TABLE_DEPTH = 32;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int ENTRY_W     = 6;
    localparam int CNT_EXT_W   = (CNT_W > ENTRY_W) ? CNT_W : ENTRY_W;

    localparam int KEY_W    = 32;
    localparam int TOKEN_W  = 64;
    localparam int SALARY_W = 24;
    localparam int AGE_W    = 7;
    localparam int REQ_W    = 2;
    localparam int STATUS_W = 2;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_INSERT = 2'd1;
    localparam logic [REQ_W-1:0] REQ_DELETE = 2'd2;
    localparam logic [REQ_W-1:0] REQ_LOOKUP = 2'd3;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_MISSING = 2'd2;

    typedef struct packed {
        logic [KEY_W-1:0]    key;
        logic [TOKEN_W-1:0]  name;
        logic [TOKEN_W-1:0]  role;
        logic [SALARY_W-1:0] salary;
        logic [AGE_W-1:0]    age;
    } t_record;

    localparam int REC_W = $bits(t_record);

    // Broadcast control from the sequencer to every cell
    typedef struct packed {
        logic             cmp_en;
        logic             load_en;
        logic             shift_en;
        logic [KEY_W-1:0] key;
        logic [CNT_W-1:0] count;
    } t_cell_ctrl;

endpackage

/* hdl/keyed_record_table_top.sv */
// Top level of the keyed record table: sequencer, cell chain, result register.
// Depends on kr_pkg and kr_cell.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+------------------------------------------
//  request | in        | i_valid / o_ready  | i_req_type, i_key, i_name_token,
//          |           |                    | i_role_token, i_salary, i_age
//  result  | out       | o_valid / i_ready  | o_status, o_found_key, o_found_name,
//          |           |                    | o_found_role, o_found_salary, o_found_age,
//          |           |                    | o_entry_count
//
// Each request passes three steps: accept, a compare step in which every cell
// compares its key against the request key, and an execute step in which the
// first-match chain resolves and the cells load, shift or gather. The match
// chain through all TABLE_DEPTH cells sets the length of the last step.
// A finished result sits in the output register; a new request is accepted
// while it waits, and the execute step holds until the register is free.
// Synchronous active-low reset empties the table and drops any pending
// transaction; the record slots themselves are not cleared.
module keyed_record_table_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [kr_pkg::REQ_W-1:0]    i_req_type,
    input  logic [kr_pkg::KEY_W-1:0]    i_key,
    input  logic [kr_pkg::TOKEN_W-1:0]  i_name_token,
    input  logic [kr_pkg::TOKEN_W-1:0]  i_role_token,
    input  logic [kr_pkg::SALARY_W-1:0] i_salary,
    input  logic [kr_pkg::AGE_W-1:0]    i_age,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [kr_pkg::STATUS_W-1:0] o_status,
    output logic [kr_pkg::KEY_W-1:0]    o_found_key,
    output logic [kr_pkg::TOKEN_W-1:0]  o_found_name,
    output logic [kr_pkg::TOKEN_W-1:0]  o_found_role,
    output logic [kr_pkg::SALARY_W-1:0] o_found_salary,
    output logic [kr_pkg::AGE_W-1:0]    o_found_age,
    output logic [kr_pkg::ENTRY_W-1:0]  o_entry_count
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_EXEC
    } t_state;

    t_state                       r_state;
    logic [kr_pkg::REQ_W-1:0]     r_req;
    kr_pkg::t_record              r_in_rec;
    logic [kr_pkg::CNT_W-1:0]     r_count;

    logic                         r_out_valid;
    logic [kr_pkg::STATUS_W-1:0]  r_status;
    kr_pkg::t_record              r_found;
    logic [kr_pkg::CNT_W-1:0]     r_out_count;

    logic [kr_pkg::CNT_W-1:0]     n_count;
    logic [kr_pkg::STATUS_W-1:0]  n_status;
    kr_pkg::t_record              n_found;

    kr_pkg::t_cell_ctrl           w_ctrl;
    kr_pkg::t_record              w_rec [0:kr_pkg::TABLE_DEPTH-1];
    logic [kr_pkg::TABLE_DEPTH:0] w_prior;
    logic [kr_pkg::TABLE_DEPTH-1:0] w_sel;
    logic [kr_pkg::REC_W-1:0]     w_gather;
    logic                         w_full;
    logic                         w_any_hit;
    logic                         w_exec_go;
    logic                         w_in_take;
    logic [kr_pkg::CNT_EXT_W-1:0] w_count_ext;

    assign o_ready   = (r_state == S_IDLE);
    assign w_in_take = i_valid && o_ready;

    // Execute only when the result register is free or being emptied
    assign w_exec_go = (r_state == S_EXEC) && (!r_out_valid || i_ready);
    assign w_full    = (r_count == kr_pkg::CNT_W'(kr_pkg::TABLE_DEPTH));
    assign w_any_hit = w_prior[kr_pkg::TABLE_DEPTH];

    always_comb begin
        w_ctrl.cmp_en   = (r_state == S_CMP);
        w_ctrl.load_en  = w_exec_go && (r_req == kr_pkg::REQ_INSERT) && !w_full;
        w_ctrl.shift_en = w_exec_go && (r_req == kr_pkg::REQ_DELETE);
        w_ctrl.key      = r_in_rec.key;
        w_ctrl.count    = r_count;
    end

    // Cell chain: match flags ripple down, records shift up toward slot 0
    assign w_prior[0] = 1'b0;

    for (genvar g = 0; g < kr_pkg::TABLE_DEPTH; g++) begin : g_cell
        kr_pkg::t_record w_next;
        if (g == kr_pkg::TABLE_DEPTH - 1) begin : g_last
            assign w_next = w_rec[g];
        end else begin : g_mid
            assign w_next = w_rec[g+1];
        end

        kr_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctrl     (w_ctrl),
            .i_index    (kr_pkg::IDX_W'(g)),
            .i_new_rec  (r_in_rec),
            .i_next_rec (w_next),
            .i_prior    (w_prior[g]),
            .o_prior    (w_prior[g+1]),
            .o_sel      (w_sel[g]),
            .o_rec      (w_rec[g])
        );
    end

    // Gather the one-hot selected record
    always_comb begin
        w_gather = '0;
        for (int i = 0; i < kr_pkg::TABLE_DEPTH; i++) begin
            w_gather = w_gather | (w_rec[i] & {kr_pkg::REC_W{w_sel[i]}});
        end
    end

    always_comb begin
        n_count  = r_count;
        n_status = kr_pkg::ST_OK;
        n_found  = '0;
        case (r_req)
            kr_pkg::REQ_CLEAR: begin
                n_count = '0;
            end
            kr_pkg::REQ_INSERT: begin
                if (w_full) begin
                    n_status = kr_pkg::ST_FULL;
                end else begin
                    n_count = r_count + kr_pkg::CNT_W'(1);
                end
            end
            kr_pkg::REQ_DELETE: begin
                if (w_any_hit) begin
                    n_count = r_count - kr_pkg::CNT_W'(1);
                end else begin
                    n_status = kr_pkg::ST_MISSING;
                end
            end
            kr_pkg::REQ_LOOKUP: begin
                if (w_any_hit) begin
                    n_found = kr_pkg::t_record'(w_gather);
                end else begin
                    n_status = kr_pkg::ST_MISSING;
                end
            end
            default: begin
                n_status = kr_pkg::ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_in_take) begin
                        r_state <= S_CMP;
                    end
                end
                S_CMP: begin
                    r_state <= S_EXEC;
                end
                S_EXEC: begin
                    if (w_exec_go) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            if (w_exec_go) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers: capture the request, then the result
    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_req           <= i_req_type;
            r_in_rec.key    <= i_key;
            r_in_rec.name   <= i_name_token;
            r_in_rec.role   <= i_role_token;
            r_in_rec.salary <= i_salary;
            r_in_rec.age    <= i_age;
        end
        if (w_exec_go) begin
            r_status    <= n_status;
            r_found     <= n_found;
            r_out_count <= n_count;
        end
    end

    assign w_count_ext = kr_pkg::CNT_EXT_W'(r_out_count);

    assign o_valid        = r_out_valid;
    assign o_status       = r_status;
    assign o_found_key    = r_found.key;
    assign o_found_name   = r_found.name;
    assign o_found_role   = r_found.role;
    assign o_found_salary = r_found.salary;
    assign o_found_age    = r_found.age;
    assign o_entry_count  = w_count_ext[kr_pkg::ENTRY_W-1:0];

endmodule

/* hdl/kr_cell.sv */
// One slot of the record chain: holds a record and its key-match flag.
// Depends on kr_pkg for the record and control types.
module kr_cell (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  kr_pkg::t_cell_ctrl       i_ctrl,
    input  logic [kr_pkg::IDX_W-1:0] i_index,
    input  kr_pkg::t_record          i_new_rec,
    input  kr_pkg::t_record          i_next_rec,
    input  logic                     i_prior,
    output logic                     o_prior,
    output logic                     o_sel,
    output kr_pkg::t_record          o_rec
);

    kr_pkg::t_record           r_rec;
    logic                      r_hit;
    logic [kr_pkg::CNT_W-1:0]  w_slot;
    logic                      w_in_range;

    assign w_slot     = kr_pkg::CNT_W'(i_index);
    assign w_in_range = w_slot < i_ctrl.count;

    // Earlier match anywhere up the chain masks this one
    assign o_sel   = r_hit & ~i_prior;
    assign o_prior = i_prior | r_hit;
    assign o_rec   = r_rec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit <= 1'b0;
        end else if (i_ctrl.cmp_en) begin
            r_hit <= (r_rec.key == i_ctrl.key) && w_in_range;
        end
    end

    // Append lands in the first free slot; delete pulls from the neighbor
    // at and after the matching slot
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load_en && (w_slot == i_ctrl.count)) begin
            r_rec <= i_new_rec;
        end else if (i_ctrl.shift_en && o_prior) begin
            r_rec <= i_next_rec;
        end
    end

endmodule

/* sim/tb_top.sv */
// Self-checking testbench for the keyed record table (keyed_record_table_top).
// Depends on kr_pkg and the RTL under hdl; needs nothing else to run.
`timescale 1ns / 1ps

module tb_top;
    import kr_pkg::*;

    // Request as queued for the driver, plus the traffic controls that ride with it.
    typedef struct packed {
        logic [REQ_W-1:0]    req;
        logic [KEY_W-1:0]    key;
        logic [TOKEN_W-1:0]  name;
        logic [TOKEN_W-1:0]  role;
        logic [SALARY_W-1:0] salary;
        logic [AGE_W-1:0]    age;
        logic [1:0]          mode;        // idle profile for both sides
        logic                drain_first; // hold off until every reply is back
        logic                hold_rx;     // start a long receiver stall
    } t_request;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [KEY_W-1:0]    key;
        logic [TOKEN_W-1:0]  name;
        logic [TOKEN_W-1:0]  role;
        logic [SALARY_W-1:0] salary;
        logic [AGE_W-1:0]    age;
        logic [ENTRY_W-1:0]  count;
    } t_reply;

    localparam logic [1:0] MODE_SLOW_RX = 2'd0; // sender idles 24%, receiver 62%
    localparam logic [1:0] MODE_SLOW_TX = 2'd1; // sender idles 62%, receiver 24%
    localparam logic [1:0] MODE_FULL    = 2'd2; // no idling on either side

    localparam int RX_HOLD_CYCLES = 300;
    localparam int RANDOM_TARGET  = 720;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic                o_ready;
    logic [REQ_W-1:0]    i_req_type = REQ_CLEAR;
    logic [KEY_W-1:0]    i_key = '0;
    logic [TOKEN_W-1:0]  i_name_token = '0;
    logic [TOKEN_W-1:0]  i_role_token = '0;
    logic [SALARY_W-1:0] i_salary = '0;
    logic [AGE_W-1:0]    i_age = '0;
    logic                o_valid;
    logic                i_ready = 1'b0;
    logic [STATUS_W-1:0] o_status;
    logic [KEY_W-1:0]    o_found_key;
    logic [TOKEN_W-1:0]  o_found_name;
    logic [TOKEN_W-1:0]  o_found_role;
    logic [SALARY_W-1:0] o_found_salary;
    logic [AGE_W-1:0]    o_found_age;
    logic [ENTRY_W-1:0]  o_entry_count;

    keyed_record_table_top u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_req_type     (i_req_type),
        .i_key          (i_key),
        .i_name_token   (i_name_token),
        .i_role_token   (i_role_token),
        .i_salary       (i_salary),
        .i_age          (i_age),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_status       (o_status),
        .o_found_key    (o_found_key),
        .o_found_name   (o_found_name),
        .o_found_role   (o_found_role),
        .o_found_salary (o_found_salary),
        .o_found_age    (o_found_age),
        .o_entry_count  (o_entry_count)
    );

    always #5 i_clk = ~i_clk;

    t_request request_queue[$];   // requests not yet offered to the block
    t_reply   reply_queue[$];     // predicted replies, oldest first
    t_request offered;            // request currently held on the input port
    int       fail_count = 0;

    // Shadow copy of the table contents, advanced once per accepted transaction.
    t_record  shadow_rows[TABLE_DEPTH];
    int       shadow_count = 0;

    logic [1:0] traffic_mode = MODE_SLOW_RX;
    logic       hold_pulse = 1'b0;
    int         rx_hold_left = 0;

    // Stimulus generator controls, picked up by add_request.
    logic [1:0]  gen_mode = MODE_SLOW_RX;
    logic        gen_drain = 1'b0;
    logic        gen_hold = 1'b0;
    logic [31:0] key_pool[12];

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Slot of the first record holding the key, or shadow_count when none does.
    function automatic int first_row(input logic [KEY_W-1:0] key);
        int i;
        for (i = 0; i < shadow_count; i++) begin
            if (shadow_rows[i].key == key)
                return i;
        end
        return shadow_count;
    endfunction

    // Apply one request to the shadow table and return the reply it must produce.
    function automatic t_reply apply_request(input t_request r);
        t_reply rep;
        int     hit;
        int     j;
        rep = '0;
        rep.status = ST_OK;
        case (r.req)
            REQ_CLEAR: begin
                shadow_count = 0;
            end
            REQ_INSERT: begin
                if (shadow_count < TABLE_DEPTH) begin
                    shadow_rows[shadow_count] = {r.key, r.name, r.role, r.salary, r.age};
                    shadow_count++;
                end else begin
                    rep.status = ST_FULL;
                end
            end
            REQ_DELETE: begin
                hit = first_row(r.key);
                if (hit < shadow_count) begin
                    // Close the gap: later records move down one slot.
                    for (j = hit; j + 1 < shadow_count; j++)
                        shadow_rows[j] = shadow_rows[j + 1];
                    shadow_count--;
                end else begin
                    rep.status = ST_MISSING;
                end
            end
            default: begin
                hit = first_row(r.key);
                if (hit < shadow_count) begin
                    rep.key    = shadow_rows[hit].key;
                    rep.name   = shadow_rows[hit].name;
                    rep.role   = shadow_rows[hit].role;
                    rep.salary = shadow_rows[hit].salary;
                    rep.age    = shadow_rows[hit].age;
                end else begin
                    rep.status = ST_MISSING;
                end
            end
        endcase
        rep.count = ENTRY_W'(shadow_count);
        return rep;
    endfunction

    function automatic int tx_idle_pct(input logic [1:0] mode);
        case (mode)
            MODE_SLOW_RX: return 24;
            MODE_SLOW_TX: return 62;
            default:      return 0;
        endcase
    endfunction

    function automatic int rx_idle_pct(input logic [1:0] mode);
        case (mode)
            MODE_SLOW_RX: return 62;
            MODE_SLOW_TX: return 24;
            default:      return 0;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Driver: offer queued requests, predict each one as it is accepted
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : request_driver
        logic   busy;
        logic   pulse;
        logic   wait_drain;
        busy  = i_valid;
        pulse = 1'b0;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            // A request is accepted here: predict its reply in acceptance order.
            if (i_valid && o_ready) begin
                reply_queue.push_back(apply_request(offered));
                busy = 1'b0;
            end
            // Hold the current payload while it waits; otherwise pick the next one.
            if (!busy) begin
                wait_drain = request_queue.size() != 0 && request_queue[0].drain_first &&
                             (reply_queue.size() != 0);
                if (request_queue.size() != 0 && !wait_drain &&
                    $urandom_range(0, 99) >= tx_idle_pct(request_queue[0].mode)) begin
                    offered = request_queue.pop_front();
                    i_req_type   <= offered.req;
                    i_key        <= offered.key;
                    i_name_token <= offered.name;
                    i_role_token <= offered.role;
                    i_salary     <= offered.salary;
                    i_age        <= offered.age;
                    traffic_mode <= offered.mode;
                    pulse = offered.hold_rx;
                    i_valid <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
        hold_pulse <= pulse;
    end

    // ------------------------------------------------------------------
    // Receiver back-pressure: random stalls plus an occasional long hold
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready      <= 1'b0;
            rx_hold_left <= 0;
        end else if (hold_pulse) begin
            // Stall long enough for the block to back up and drop o_ready.
            i_ready      <= 1'b0;
            rx_hold_left <= RX_HOLD_CYCLES;
        end else if (rx_hold_left != 0) begin
            i_ready      <= 1'b0;
            rx_hold_left <= rx_hold_left - 1;
        end else begin
            i_ready <= $urandom_range(0, 99) >= rx_idle_pct(traffic_mode);
        end
    end

    // ------------------------------------------------------------------
    // Monitor: compare every accepted reply with the oldest prediction
    // ------------------------------------------------------------------
    task automatic check_field(input string label, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, label, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin : reply_monitor
        t_reply want;
        if (i_rst_n && o_valid && i_ready) begin
            if (reply_queue.size() == 0) begin
                $display("%0t: reply with nothing outstanding, status %0d count %0d",
                         $time, o_status, o_entry_count);
                fail_count++;
            end else begin
                want = reply_queue.pop_front();
                check_field("status",       64'(want.status), 64'(o_status));
                check_field("found_key",    64'(want.key),    64'(o_found_key));
                check_field("found_name",   want.name,        o_found_name);
                check_field("found_role",   want.role,        o_found_role);
                check_field("found_salary", 64'(want.salary), 64'(o_found_salary));
                check_field("found_age",    64'(want.age),    64'(o_found_age));
                check_field("entry_count",  64'(want.count),  64'(o_entry_count));
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic add_request(input logic [REQ_W-1:0] req, input logic [KEY_W-1:0] key,
                               input logic [TOKEN_W-1:0] name,
                               input logic [TOKEN_W-1:0] role,
                               input logic [SALARY_W-1:0] salary,
                               input logic [AGE_W-1:0] age);
        t_request r;
        r.req         = req;
        r.key         = key;
        r.name        = name;
        r.role        = role;
        r.salary      = salary;
        r.age         = age;
        r.mode        = gen_mode;
        r.drain_first = gen_drain;
        r.hold_rx     = gen_hold;
        gen_drain = 1'b0;
        gen_hold  = 1'b0;
        request_queue.push_back(r);
    endtask

    // Mostly keys from a small pool so lookups and deletes hit and duplicates occur.
    function automatic logic [KEY_W-1:0] pick_key();
        if ($urandom_range(0, 99) < 75)
            return key_pool[$urandom_range(0, 11)];
        return $urandom;
    endfunction

    // One random request; whatever the three weights leave over goes to clear.
    task automatic add_random(input int ins_pct, input int del_pct, input int look_pct);
        int               roll;
        logic [REQ_W-1:0] req;
        roll = $urandom_range(0, 99);
        if (roll < ins_pct)
            req = REQ_INSERT;
        else if (roll < ins_pct + del_pct)
            req = REQ_DELETE;
        else if (roll < ins_pct + del_pct + look_pct)
            req = REQ_LOOKUP;
        else
            req = REQ_CLEAR;
        add_request(req, pick_key(), {$urandom, $urandom}, {$urandom, $urandom},
                    SALARY_W'($urandom_range(0, 24'hFFFFFF)),
                    AGE_W'($urandom_range(0, 127)));
    endtask

    initial begin : main_sequence
        int         i;
        int         episode;
        int         kind;
        logic [1:0] last_mode;

        key_pool[0] = 32'h0000_0000;
        key_pool[1] = 32'hFFFF_FFFF;
        for (i = 2; i < 12; i++)
            key_pool[i] = $urandom;

        // Directed part: empty-table misses, field extremes, duplicates, shifts, clear.
        add_request(REQ_LOOKUP, 32'h0000_0000, '0, '0, '0, '0);
        add_request(REQ_DELETE, 32'hFFFF_FFFF, '0, '0, '0, '0);
        add_request(REQ_CLEAR,  32'h0000_0000, '0, '0, '0, '0);
        add_request(REQ_INSERT, 32'h0000_0000, '0, '0, '0, '0);
        add_request(REQ_INSERT, 32'hFFFF_FFFF, '1, '1, 24'hFFFFFF, 7'd127);
        add_request(REQ_INSERT, 32'h0000_0000, "DUPENTRY", "MANAGER ", 24'd52000, 7'd41);
        add_request(REQ_LOOKUP, 32'h0000_0000, '1, '1, '1, '1);
        add_request(REQ_LOOKUP, 32'hFFFF_FFFF, '0, '0, '0, '0);
        add_request(REQ_LOOKUP, 32'h1234_5678, '0, '0, '0, '0);
        add_request(REQ_DELETE, 32'h0000_0000, '0, '0, '0, '0);
        add_request(REQ_LOOKUP, 32'h0000_0000, '0, '0, '0, '0);
        add_request(REQ_DELETE, 32'hFFFF_FFFF, '0, '0, '0, '0);
        add_request(REQ_LOOKUP, 32'h0000_0000, '0, '0, '0, '0);
        add_request(REQ_INSERT, 32'hAAAA_AAAA, {4{16'h5555}}, {4{16'hAAAA}},
                    24'h555555, 7'h2A);
        add_request(REQ_INSERT, 32'h5555_5555, {4{16'hAAAA}}, {4{16'h5555}},
                    24'hAAAAAA, 7'h55);
        add_request(REQ_LOOKUP, 32'hAAAA_AAAA, '0, '0, '0, '0);
        add_request(REQ_DELETE, 32'h5555_5555, '0, '0, '0, '0);
        add_request(REQ_LOOKUP, 32'h5555_5555, '0, '0, '0, '0);
        add_request(REQ_CLEAR,  32'hFFFF_FFFF, '1, '1, '1, '1);
        add_request(REQ_LOOKUP, 32'hAAAA_AAAA, '0, '0, '0, '0);

        // Random part in episodes: fill to full, drain down, or a general mix.
        // Each switch of idle profile drains first and starts a long receiver hold.
        episode   = 0;
        last_mode = MODE_SLOW_RX;
        while (request_queue.size() < RANDOM_TARGET) begin
            if (request_queue.size() >= 480)
                gen_mode = MODE_FULL;
            else if (request_queue.size() >= 240)
                gen_mode = MODE_SLOW_TX;
            else
                gen_mode = MODE_SLOW_RX;
            if (gen_mode != last_mode) begin
                gen_drain = 1'b1;
                gen_hold  = 1'b1;
                last_mode = gen_mode;
            end else if (episode % 5 == 4) begin
                gen_drain = 1'b1;
            end
            kind = (episode == 0) ? 0 : $urandom_range(0, 2);
            case (kind)
                0: begin
                    add_request(REQ_CLEAR, pick_key(), {$urandom, $urandom},
                                {$urandom, $urandom}, SALARY_W'($urandom),
                                AGE_W'($urandom));
                    repeat (45) add_random(80, 0, 20);
                end
                1: repeat (30) add_random(10, 50, 40);
                default: repeat (25) add_random(40, 25, 30);
            endcase
            episode++;
        end

        // Release reset; the driver starts offering right after.
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for every request to go out and every reply to come back; sample
        // away from the active edge so the driver's updates have settled.
        while (request_queue.size() != 0 || i_valid || reply_queue.size() != 0)
            @(negedge i_clk);
        // Let any stray reply show up before the verdict.
        repeat (20) @(posedge i_clk);

        if (fail_count == 0 && reply_queue.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Hard stop far beyond the slowest legal run.
    initial begin
        #2000000;
        $display("Some tests failed");
        $finish;
    end

endmodule
